### rtl/core/led_display_two_wire_writer_macros.svh
// Assertion macros for the two-wire LED display writer.
// Depends on nothing; included by the files that carry assertions.
`ifndef LED_DISPLAY_TWO_WIRE_WRITER_MACROS_SVH
`define LED_DISPLAY_TWO_WIRE_WRITER_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define LEDW_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define LEDW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/core/ledw_pkg.sv
// Shared types and constants for the two-wire LED display writer.
// Used by every module of the block; depends on nothing.
package ledw_pkg;

  localparam int MAX_DIGITS = 6;
  localparam int IDX_W = $clog2(MAX_DIGITS + 2);

  localparam logic [7:0] CMD_AUTO  = 8'h40;
  localparam logic [7:0] CMD_FIXED = 8'h44;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] CTRL_BASE = 8'h88;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FIXED = 2'd2,
    OP_AUTO  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] address;
    logic [7:0] segment_data;
    logic [2:0] byte_count;
  } item_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

### rtl/core/ledw_in_reg.sv
// Input register of the LED display writer: holds one request.
// Depends on ledw_pkg.
module ledw_in_reg import ledw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  full,
  output item_t item
);

  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### rtl/core/ledw_seq.sv
// Pin sequencer of the LED display writer: digit buffer, update state and
// one pin action per tick during an update. Depends on ledw_pkg.
module ledw_seq import ledw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_data,
  input  logic       advance,
  input  item_t      item,
  output res_t       res
);

  typedef enum logic [1:0] {PART_START, PART_BYTES, PART_STOP} part_t;
  typedef enum logic [1:0] {FRAME_CMD, FRAME_DATA, FRAME_CTRL} frame_t;

  logic [7:0]       digit_buffer [MAX_DIGITS];
  logic [7:0]       digit_buffer_next [MAX_DIGITS];
  logic [2:0]       brightness;
  logic             clk_reg, clk_reg_next;
  logic             dio_reg, dio_reg_next;
  logic             drive_reg, drive_reg_next;
  logic             busy_reg, busy_reg_next;
  part_t            part, part_next;
  frame_t           frame_no, frame_no_next;
  logic [4:0]       frame_step, frame_step_next;
  logic [1:0]       phase, phase_next;
  logic [IDX_W-1:0] byte_idx, byte_idx_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic             upd_auto, upd_auto_next;
  logic [2:0]       upd_addr, upd_addr_next;
  logic [7:0]       upd_data, upd_data_next;
  logic [IDX_W-1:0] upd_count, upd_count_next;
  logic [7:0]       frame_byte;
  logic [IDX_W:0]   frame_bytes;
  logic [IDX_W-1:0] buf_idx;
  logic             rej;
  op_t              op;

  assign op = op_t'(item.operation);
  assign buf_idx = byte_idx - IDX_W'(1);

  always_comb begin
    frame_byte = 8'h00;
    case (frame_no)
      FRAME_CMD:  frame_byte = upd_auto ? CMD_AUTO : CMD_FIXED;
      FRAME_CTRL: frame_byte = CTRL_BASE | {5'd0, brightness};
      FRAME_DATA: begin
        if (byte_idx == '0) begin
          frame_byte = ADDR_BASE | (upd_auto ? 8'h00 : {5'd0, upd_addr});
        end else if (!upd_auto) begin
          frame_byte = upd_data;
        end else if (32'(buf_idx) < MAX_DIGITS) begin
          frame_byte = digit_buffer[buf_idx];
        end
      end
      default: frame_byte = 8'h00;
    endcase
    if (frame_no == FRAME_DATA) begin
      frame_bytes = upd_auto ? ((IDX_W+1)'(upd_count) + (IDX_W+1)'(1)) : (IDX_W+1)'(2);
    end else begin
      frame_bytes = (IDX_W+1)'(1);
    end
  end

  always_comb begin
    digit_buffer_next = digit_buffer;
    clk_reg_next      = clk_reg;
    dio_reg_next      = dio_reg;
    drive_reg_next    = drive_reg;
    busy_reg_next     = busy_reg;
    part_next         = part;
    frame_no_next     = frame_no;
    frame_step_next   = frame_step;
    phase_next        = phase;
    byte_idx_next     = byte_idx;
    shift_byte_next   = shift_byte;
    upd_auto_next     = upd_auto;
    upd_addr_next     = upd_addr;
    upd_data_next     = upd_data;
    upd_count_next    = upd_count;
    rej               = 1'b0;
    if (op == OP_TICK) begin
      if (busy_reg) begin
        case (part)
          PART_START: begin
            drive_reg_next  = 1'b1;
            dio_reg_next    = 1'b0;
            part_next       = PART_BYTES;
            byte_idx_next   = '0;
            frame_step_next = '0;
            phase_next      = '0;
          end
          PART_BYTES: begin
            if (frame_step < 5'd24) begin
              case (phase)
                2'd0: begin
                  if (frame_step == '0) begin
                    shift_byte_next = frame_byte;
                  end
                  drive_reg_next = 1'b1;
                  clk_reg_next   = 1'b0;
                end
                2'd1: begin
                  dio_reg_next    = shift_byte[0];
                  shift_byte_next = {1'b0, shift_byte[7:1]};
                end
                default: clk_reg_next = 1'b1;
              endcase
              frame_step_next = frame_step + 5'd1;
              phase_next      = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
            end else if (frame_step == 5'd24) begin
              drive_reg_next  = 1'b0;
              clk_reg_next    = 1'b0;
              frame_step_next = frame_step + 5'd1;
            end else if (frame_step == 5'd25) begin
              clk_reg_next    = 1'b1;
              frame_step_next = frame_step + 5'd1;
            end else begin
              clk_reg_next    = 1'b0;
              frame_step_next = '0;
              phase_next      = '0;
              byte_idx_next   = byte_idx + IDX_W'(1);
              if ((IDX_W+1)'(byte_idx) + (IDX_W+1)'(1) >= frame_bytes) begin
                part_next = PART_STOP;
              end
            end
          end
          default: begin
            if (frame_step == '0) begin
              drive_reg_next  = 1'b1;
              dio_reg_next    = 1'b0;
              frame_step_next = 5'd1;
            end else if (frame_step == 5'd1) begin
              clk_reg_next    = 1'b1;
              frame_step_next = 5'd2;
            end else begin
              dio_reg_next    = 1'b1;
              frame_step_next = '0;
              part_next       = PART_START;
              if (frame_no == FRAME_CTRL) begin
                frame_no_next = FRAME_CMD;
                busy_reg_next = 1'b0;
              end else begin
                frame_no_next = frame_t'(frame_no + 2'd1);
              end
            end
          end
        endcase
      end
    end else if (busy_reg) begin
      rej = 1'b1;
    end else if (op == OP_WRITE) begin
      if (32'(item.address) < MAX_DIGITS) begin
        digit_buffer_next[item.address] = item.segment_data;
      end
    end else begin
      upd_auto_next   = (op == OP_AUTO);
      upd_addr_next   = item.address;
      upd_data_next   = item.segment_data;
      upd_count_next  = (32'(item.byte_count) > MAX_DIGITS) ? IDX_W'(MAX_DIGITS)
                                                           : IDX_W'(item.byte_count);
      frame_no_next   = FRAME_CMD;
      part_next       = PART_START;
      byte_idx_next   = '0;
      frame_step_next = '0;
      phase_next      = '0;
      busy_reg_next   = 1'b1;
    end
  end

  assign res.clk_level = clk_reg_next;
  assign res.dio_level = dio_reg_next;
  assign res.dio_drive = drive_reg_next;
  assign res.busy_res  = busy_reg_next;
  assign res.rejected  = rej;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit_buffer[i] <= 8'h00;
      end
      brightness <= 3'd7;
      clk_reg    <= 1'b1;
      dio_reg    <= 1'b1;
      drive_reg  <= 1'b1;
      busy_reg   <= 1'b0;
      part       <= PART_START;
      frame_no   <= FRAME_CMD;
      frame_step <= '0;
      phase      <= '0;
      byte_idx   <= '0;
      shift_byte <= '0;
      upd_auto   <= 1'b0;
      upd_addr   <= '0;
      upd_data   <= '0;
      upd_count  <= '0;
    end else begin
      if (cfg_write) begin
        brightness <= cfg_data;
      end
      if (advance) begin
        digit_buffer <= digit_buffer_next;
        clk_reg      <= clk_reg_next;
        dio_reg      <= dio_reg_next;
        drive_reg    <= drive_reg_next;
        busy_reg     <= busy_reg_next;
        part         <= part_next;
        frame_no     <= frame_no_next;
        frame_step   <= frame_step_next;
        phase        <= phase_next;
        byte_idx     <= byte_idx_next;
        shift_byte   <= shift_byte_next;
        upd_auto     <= upd_auto_next;
        upd_addr     <= upd_addr_next;
        upd_data     <= upd_data_next;
        upd_count    <= upd_count_next;
      end
    end
  end

endmodule

### rtl/core/ledw_out_reg.sv
// Result register of the LED display writer: holds one result until taken.
// Depends on ledw_pkg.
module ledw_out_reg import ledw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  output logic load_ok,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= load;
    end
    if (load && load_ok) begin
      res <= res_in;
    end
  end

endmodule

### rtl/core/led_display_two_wire_writer.sv
// Two-wire LED display writer: one pin action or buffer request per result.
// Top level; depends on ledw_pkg, ledw_in_reg, ledw_seq, ledw_out_reg and
// led_display_two_wire_writer_macros.svh.
//
// Requests enter on in_valid/in_ready with operation, address, segment_data
// and byte_count. A tick advances a running update by one pin action; a
// buffer write stores a segment byte; a fixed or auto command starts an
// update. Writes and commands that arrive during an update are flagged
// through rejected and change nothing.
// Each request gives exactly one result on out_valid/out_ready: the clock
// and data line levels, the data drive enable, busy and rejected.
// A request is captured in the input register, and its result is loaded into
// the result register once that register can take it.
// One request is accepted per cycle unless the receiver stalls; the state update
// between the two registers is a single pass of logic.
// While the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until the result is taken. The user writes brightness by
// cfg_write/cfg_data while no request is in flight, unchecked by the block.
// Reset sets both lines high and driven, brightness to 7, clears the digit
// buffer and empties both registers.
`include "led_display_two_wire_writer_macros.svh"
module led_display_two_wire_writer import ledw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [2:0] address,
  input  logic [7:0] segment_data,
  input  logic [2:0] byte_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       clk_level,
  output logic       dio_level,
  output logic       dio_drive,
  output logic       busy_res,
  output logic       rejected,
  input  logic       cfg_write,
  input  logic [2:0] cfg_data
);

  item_t in_item;
  item_t item;
  res_t  step_res;
  res_t  res;
  logic  full;
  logic  load_ok;
  logic  advance;

  assign in_item.operation    = operation;
  assign in_item.address      = address;
  assign in_item.segment_data = segment_data;
  assign in_item.byte_count   = byte_count;
  assign advance              = full && load_ok;

  ledw_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (advance),
    .full     (full),
    .item     (item)
  );

  ledw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .res       (step_res)
  );

  ledw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (full),
    .res_in    (step_res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign clk_level = res.clk_level;
  assign dio_level = res.dio_level;
  assign dio_drive = res.dio_drive;
  assign busy_res  = res.busy_res;
  assign rejected  = res.rejected;

  // A rejected request can only come while an update runs.
  `LEDW_ASSERT_NOW(a_rej_busy, out_valid && rejected, busy_res, "rejected while idle")
  // The data line is released only inside an update.
  `LEDW_ASSERT_NOW(a_release_busy, out_valid && !dio_drive, busy_res, "released while idle")
  // Idle lines rest high and driven.
  `LEDW_ASSERT_NOW(a_idle_lines, out_valid && !busy_res,
                   clk_level && dio_level && dio_drive, "idle lines not high")
  // A stalled full input register moves no request forward.
  `LEDW_ASSERT_NEXT(a_stall_hold, full && out_valid && !out_ready, full, "request lost in stall")

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-wire LED display writer.
// Holds a pin-level model of the update sequencer and scoreboard in one class;
// it depends only on ledw_pkg and the led_display_two_wire_writer RTL.
import ledw_pkg::*;

class pin_trace_model;
  localparam int PART_START = 0;
  localparam int PART_BYTES = 1;
  localparam int PART_STOP  = 2;
  localparam int FRAME_CMD  = 0;
  localparam int FRAME_ADDR = 1;
  localparam int FRAME_CTRL = 2;

  logic [7:0] digit_buf [MAX_DIGITS];
  bit clk_q, dio_q, drive_q, busy_q;
  int unsigned step, part, frame_no, byte_idx, upd_count;
  bit upd_auto;
  logic [2:0] upd_addr;
  logic [7:0] upd_data;
  logic [7:0] shifter;
  logic [2:0] level;
  res_t expected_pins [$];
  int unsigned mismatches, checked, fixed_updates, auto_updates, rejections, pin_actions;

  function new();
    foreach (digit_buf[i]) digit_buf[i] = 8'h00;
    clk_q = 1'b1;
    dio_q = 1'b1;
    drive_q = 1'b1;
    busy_q = 1'b0;
    step = 0;
    part = PART_START;
    frame_no = FRAME_CMD;
    byte_idx = 0;
    upd_count = 0;
    upd_auto = 1'b0;
    upd_addr = 3'd0;
    upd_data = 8'h00;
    shifter = 8'h00;
    level = 3'd7;
  endfunction

  function int unsigned frame_len();
    if (frame_no == FRAME_ADDR) return upd_auto ? 1 + upd_count : 2;
    return 1;
  endfunction

  function logic [7:0] next_byte();
    if (frame_no == FRAME_CMD) return upd_auto ? CMD_AUTO : CMD_FIXED;
    if (frame_no == FRAME_CTRL) return CTRL_BASE | {5'b00000, level};
    if (byte_idx == 0) return ADDR_BASE | {5'b00000, (upd_auto ? 3'd0 : upd_addr)};
    if (!upd_auto) return upd_data;
    return digit_buf[byte_idx - 1];
  endfunction

  function void pin_action();
    pin_actions++;
    if (part == PART_START) begin
      drive_q = 1'b1;
      dio_q = 1'b0;
      part = PART_BYTES;
      byte_idx = 0;
      step = 0;
    end else if (part == PART_BYTES) begin
      if (step < 24) begin
        case (step % 3)
          0: begin
            if (step == 0) shifter = next_byte();
            drive_q = 1'b1;
            clk_q = 1'b0;
          end
          1: begin
            dio_q = shifter[0];
            shifter = shifter >> 1;
          end
          default: clk_q = 1'b1;
        endcase
        step++;
      end else if (step == 24) begin
        drive_q = 1'b0;
        clk_q = 1'b0;
        step++;
      end else if (step == 25) begin
        clk_q = 1'b1;
        step++;
      end else begin
        clk_q = 1'b0;
        step = 0;
        byte_idx++;
        if (byte_idx >= frame_len()) part = PART_STOP;
      end
    end else begin
      if (step == 0) begin
        drive_q = 1'b1;
        dio_q = 1'b0;
        step = 1;
      end else if (step == 1) begin
        clk_q = 1'b1;
        step = 2;
      end else begin
        dio_q = 1'b1;
        step = 0;
        frame_no++;
        part = PART_START;
        if (frame_no > FRAME_CTRL) begin
          frame_no = FRAME_CMD;
          busy_q = 1'b0;
        end
      end
    end
  endfunction

  function void note_request(item_t it);
    res_t r;
    bit rej;
    rej = 1'b0;
    case (op_t'(it.operation))
      OP_TICK: begin
        if (busy_q) pin_action();
      end
      OP_WRITE: begin
        if (busy_q) rej = 1'b1;
        else if (it.address < MAX_DIGITS) digit_buf[it.address] = it.segment_data;
      end
      default: begin
        if (busy_q) begin
          rej = 1'b1;
        end else begin
          upd_auto = (op_t'(it.operation) == OP_AUTO);
          upd_addr = it.address;
          upd_data = it.segment_data;
          upd_count = (it.byte_count > MAX_DIGITS) ? MAX_DIGITS : it.byte_count;
          frame_no = FRAME_CMD;
          part = PART_START;
          byte_idx = 0;
          step = 0;
          busy_q = 1'b1;
          if (upd_auto) auto_updates++;
          else fixed_updates++;
        end
      end
    endcase
    if (rej) rejections++;
    r.clk_level = clk_q;
    r.dio_level = dio_q;
    r.dio_drive = drive_q;
    r.busy_res = busy_q;
    r.rejected = rej;
    expected_pins.push_back(r);
  endfunction

  function void check_result(res_t got);
    res_t exp;
    if (expected_pins.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Result arrived with no request pending: %b", got);
      return;
    end
    exp = expected_pins.pop_front();
    checked++;
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch %0d exp/act: clk %b/%b dio %b/%b drv %b/%b busy %b/%b rej %b/%b",
                 checked, exp.clk_level, got.clk_level, exp.dio_level, got.dio_level,
                 exp.dio_drive, got.dio_drive, exp.busy_res, got.busy_res,
                 exp.rejected, got.rejected);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = OP_TICK;
  logic [2:0] address = 3'd0;
  logic [7:0] segment_data = 8'h00;
  logic [2:0] byte_count = 3'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic clk_level, dio_level, dio_drive, busy_res, rejected;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_data = 3'd0;

  bit send_gaps = 1'b1;
  bit take_gaps = 1'b1;
  int unsigned hold_off = 0;
  int unsigned cycle_count = 0;
  pin_trace_model trace = new();

  led_display_two_wire_writer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .address(address),
    .segment_data(segment_data),
    .byte_count(byte_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .clk_level(clk_level),
    .dio_level(dio_level),
    .dio_drive(dio_drive),
    .busy_res(busy_res),
    .rejected(rejected),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic item_t req(op_t op, int unsigned addr, int unsigned data,
                                int unsigned count);
    item_t it;
    it.operation = op;
    it.address = 3'(addr);
    it.segment_data = 8'(data);
    it.byte_count = 3'(count);
    return it;
  endfunction

  function automatic item_t pick_request(bit busy);
    item_t it;
    int unsigned roll;
    it = req(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (busy) begin
      if (roll < 2) it.operation = OP_WRITE;
      else if (roll < 4) it.operation = OP_FIXED;
      else if (roll < 6) it.operation = OP_AUTO;
    end else begin
      if (roll < 50) begin
        it.operation = OP_WRITE;
        it.address = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 5))
                                                : 3'($urandom_range(6, 7));
      end else if (roll < 70) begin
        it.operation = OP_FIXED;
      end else if (roll < 95) begin
        it.operation = OP_AUTO;
        if ($urandom_range(0, 3) != 0) it.byte_count = 3'($urandom_range(0, 2));
      end
    end
    return it;
  endfunction

  task automatic send_request(input item_t it);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.operation;
    address <= it.address;
    segment_data <= it.segment_data;
    byte_count <= it.byte_count;
    do @(posedge clk); while (!in_ready);
    trace.note_request(it);
  endtask

  task automatic run_out_update();
    while (trace.busy_q)
      send_request(req(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                       $urandom_range(0, 7)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (trace.expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [2:0] lvl);
    cfg_write <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    cfg_write <= 1'b0;
    trace.level = lvl;
  endtask

  initial begin : result_taker
    res_t got;
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      stall = take_gaps ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {clk_level, dio_level, dio_drive, busy_res, rejected};
      trace.check_result(got);
    end
  end

  initial begin : stimulus
    item_t it;
    int unsigned done;
    bit paused;
    bit live;
    logic [2:0] levels [5];
    levels = '{3'd0, 3'd7, 3'd5, 3'd2, 3'd0};
    levels[4] = 3'($urandom_range(0, 7));
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(req(OP_TICK, 7, 255, 7));
    send_request(req(OP_WRITE, 0, 255, 0));
    send_request(req(OP_WRITE, 1, 8'hA5, 7));
    send_request(req(OP_WRITE, 5, 8'h5A, 0));
    send_request(req(OP_WRITE, 6, 8'h12, 0));
    send_request(req(OP_WRITE, 7, 8'h34, 0));
    send_request(req(OP_FIXED, 7, 255, 7));
    send_request(req(OP_TICK, 0, 0, 0));
    send_request(req(OP_WRITE, 2, 8'h77, 0));
    send_request(req(OP_FIXED, 1, 8'h01, 0));
    send_request(req(OP_AUTO, 0, 8'h00, 3));
    run_out_update();
    send_request(req(OP_AUTO, 5, 8'hFF, 0));
    run_out_update();
    send_request(req(OP_AUTO, 2, 8'h3C, 7));
    run_out_update();
    settle();

    for (int p = 0; p < 5; p++) begin
      send_gaps = (p != 1) && (p != 3);
      take_gaps = (p != 1) && (p != 2);
      write_brightness(levels[p]);
      if (p == 1) hold_off = 90;
      done = 0;
      paused = 1'b0;
      while (done < PHASE_ITEMS) begin
        it = pick_request(trace.busy_q);
        if (trace.busy_q) live = (op_t'(it.operation) == OP_TICK);
        else live = (op_t'(it.operation) != OP_TICK) &&
                    !(op_t'(it.operation) == OP_WRITE && it.address >= MAX_DIGITS);
        if (live) done++;
        send_request(it);
        if (p == 3 && !paused && done >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          settle();
        end
      end
      settle();
    end
    run_out_update();
    settle();

    repeat (16) @(posedge clk);
    $display("Checked %0d results with %0d mismatches over %0d fixed and %0d auto updates.",
             trace.checked, trace.mismatches, trace.fixed_updates, trace.auto_updates);
    $display("Brightness 7, %0d, %0d, %0d, %0d, %0d; %0d pin actions, %0d rejections.",
             levels[0], levels[1], levels[2], levels[3], levels[4], trace.pin_actions,
             trace.rejections);
    if (trace.mismatches == 0 && trace.expected_pins.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ledw_pkg.sv
rtl/core/ledw_in_reg.sv
rtl/core/ledw_seq.sv
rtl/core/ledw_out_reg.sv
rtl/core/led_display_two_wire_writer.sv
verif/tb_top.sv
